FILE: rtl/armt_pkg.sv
// Package: table size, derived widths, placement codes, FSM states, control structs.
`timescale 1ns / 1ps

package armt_pkg;

    // Number of entries in the coalesced range table (1 to 8)
    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W  = 32;
    localparam int PLACE_W = 2;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;
    localparam int TOTAL_W = 16;

    typedef enum logic [PLACE_W-1:0] {
        PLACE_MERGE  = 2'd0,
        PLACE_APPEND = 2'd1,
        PLACE_DROP   = 2'd2
    } t_place;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_armt_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the incoming item, clear the list if flagged
        logic advance;  // step to the next stored entry
        logic merge;    // widen the current entry
        logic append;   // write a new entry
        logic drop;     // table full, set the sticky flag
    } t_armt_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_end; // every stored entry has been checked
        logic hit;      // item start or end falls in or next to the current entry
        logic full;     // table holds TABLE_ENTRIES entries
    } t_armt_sts;

endpackage

FILE: rtl/armt_ctrl.sv
// Controller: sequences the accept, the entry scan and the result handoff.
`timescale 1ns / 1ps

module armt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready,
    input  armt_pkg::t_armt_sts i_sts,
    output logic                o_ready,
    output logic                o_valid,
    output armt_pkg::t_armt_cmd o_cmd
);

    armt_pkg::t_armt_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= armt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            armt_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = armt_pkg::ST_SCAN;
                end
            end
            armt_pkg::ST_SCAN: begin
                if (i_sts.scan_end) begin
                    if (i_sts.full) begin
                        o_cmd.drop = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                    n_state = armt_pkg::ST_DONE;
                end else if (i_sts.hit) begin
                    o_cmd.merge = 1'b1;
                    n_state     = armt_pkg::ST_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            armt_pkg::ST_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = armt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = armt_pkg::ST_IDLE;
            end
        endcase
    end

    // At most one placement command at a time, each followed by a result
    a_one_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.merge, o_cmd.append, o_cmd.drop}) <= 1)
        else $error("more than one placement command");
    a_place_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.merge || o_cmd.append || o_cmd.drop) |=> o_valid)
        else $error("placement not followed by a result");
    a_load_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_valid && !o_ready)
        else $error("load not followed by a scan");

endmodule

FILE: rtl/armt_dp.sv
// Datapath: range table, entry compare and merge, list totals and result registers.
`timescale 1ns / 1ps

module armt_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  armt_pkg::t_armt_cmd                  i_cmd,
    input  logic [armt_pkg::ADDR_W-1:0]          i_range_start,
    input  logic [armt_pkg::ADDR_W-1:0]          i_range_end,
    input  logic                                 i_list_first,
    output armt_pkg::t_armt_sts                  o_sts,
    output logic [armt_pkg::PLACE_W-1:0]         o_placement,
    output logic [armt_pkg::SLOT_W-1:0]          o_slot_index,
    output logic [armt_pkg::ADDR_W-1:0]          o_slot_start,
    output logic [armt_pkg::ADDR_W-1:0]          o_slot_end,
    output logic [armt_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                 o_overflowed,
    output logic [armt_pkg::TOTAL_W-1:0]         o_range_count,
    output logic [armt_pkg::ADDR_W-1:0]          o_lowest_start,
    output logic [armt_pkg::ADDR_W-1:0]          o_highest_end
);

    localparam logic [armt_pkg::CNT_W-1:0] FULL_CNT = armt_pkg::CNT_W'(armt_pkg::TABLE_ENTRIES);

    // Table storage, not reset: entries below r_used are always written
    logic [armt_pkg::ADDR_W-1:0]  r_starts [armt_pkg::TABLE_ENTRIES];
    logic [armt_pkg::ADDR_W-1:0]  r_ends   [armt_pkg::TABLE_ENTRIES];

    logic [armt_pkg::ADDR_W-1:0]  r_s, r_e;
    logic [armt_pkg::CNT_W-1:0]   r_idx;
    logic [armt_pkg::CNT_W-1:0]   r_used;
    logic                         r_full;
    logic [armt_pkg::TOTAL_W-1:0] r_cnt;
    logic [armt_pkg::ADDR_W-1:0]  r_min, r_max;
    armt_pkg::t_place             r_place;
    logic [armt_pkg::SLOT_W-1:0]  r_slot;
    logic [armt_pkg::ADDR_W-1:0]  r_slot_s, r_slot_e;

    logic [armt_pkg::IDX_W-1:0]   w_rd_idx, w_wr_idx;
    logic [armt_pkg::ADDR_W-1:0]  w_es, w_ee, w_ee_up, w_es_dn;
    logic [armt_pkg::ADDR_W-1:0]  w_new_s, w_new_e;
    logic                         w_finish;

    // Compare the item against the entry under the scan pointer
    assign w_rd_idx = r_idx[armt_pkg::IDX_W-1:0];
    assign w_wr_idx = r_used[armt_pkg::IDX_W-1:0];
    assign w_es     = r_starts[w_rd_idx];
    assign w_ee     = r_ends[w_rd_idx];
    assign w_ee_up  = w_ee + 32'd1;
    assign w_es_dn  = w_es - 32'd1;
    assign w_new_s  = (r_s < w_es) ? r_s : w_es;
    assign w_new_e  = (r_e > w_ee) ? r_e : w_ee;
    assign w_finish = i_cmd.merge | i_cmd.append | i_cmd.drop;

    always_comb begin
        o_sts.scan_end = (r_idx >= r_used);
        o_sts.hit      = ((r_s >= w_es) && (r_s <= w_ee_up)) ||
                         ((r_e >= w_es_dn) && (r_e <= w_ee));
        o_sts.full     = (r_used >= FULL_CNT);
    end

    // Table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.merge) begin
            r_starts[w_rd_idx] <= w_new_s;
            r_ends[w_rd_idx]   <= w_new_e;
        end else if (i_cmd.append) begin
            r_starts[w_wr_idx] <= r_s;
            r_ends[w_wr_idx]   <= r_e;
        end
    end

    // Item latch and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= i_range_start;
            r_e <= i_range_end;
        end
        if (i_cmd.merge) begin
            r_place  <= armt_pkg::PLACE_MERGE;
            r_slot   <= armt_pkg::SLOT_W'(r_idx);
            r_slot_s <= w_new_s;
            r_slot_e <= w_new_e;
        end else if (i_cmd.append) begin
            r_place  <= armt_pkg::PLACE_APPEND;
            r_slot   <= armt_pkg::SLOT_W'(r_used);
            r_slot_s <= r_s;
            r_slot_e <= r_e;
        end else if (i_cmd.drop) begin
            r_place  <= armt_pkg::PLACE_DROP;
            r_slot   <= '0;
            r_slot_s <= '0;
            r_slot_e <= '0;
        end
    end

    // Scan pointer, fill count and list totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_used <= '0;
            r_full <= 1'b0;
            r_cnt  <= '0;
            r_min  <= '1;
            r_max  <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
            if (i_list_first) begin
                r_used <= '0;
                r_full <= 1'b0;
                r_cnt  <= '0;
                r_min  <= '1;
                r_max  <= '0;
            end
        end else begin
            if (i_cmd.advance) begin
                r_idx <= r_idx + armt_pkg::CNT_W'(1);
            end
            if (i_cmd.append) begin
                r_used <= r_used + armt_pkg::CNT_W'(1);
            end
            if (i_cmd.drop) begin
                r_full <= 1'b1;
            end
            if (w_finish) begin
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + armt_pkg::TOTAL_W'(1);
                end
                if (r_s < r_min) begin
                    r_min <= r_s;
                end
                if (r_e > r_max) begin
                    r_max <= r_e;
                end
            end
        end
    end

    assign o_placement    = r_place;
    assign o_slot_index   = r_slot;
    assign o_slot_start   = r_slot_s;
    assign o_slot_end     = r_slot_e;
    assign o_entry_count  = armt_pkg::COUNT_W'(r_used);
    assign o_overflowed   = r_full;
    assign o_range_count  = r_cnt;
    assign o_lowest_start = r_min;
    assign o_highest_end  = r_max;

    // Fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_CNT)
        else $error("fill count beyond table size");
    // Append only when room; a drop sets the full flag
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_used < FULL_CNT))
        else $error("append into a full table");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop |=> r_full)
        else $error("drop did not set the full flag");

endmodule

FILE: rtl/address_range_merge_table_core.sv
// Top level: coalesced watch range table, controller plus datapath.
// Sequence: after the accept edge the scan steps through the stored entries in
//   order, ending on the first match, or on one step past the last entry; then o_valid.
// Flow: one item at a time; the next item is taken the cycle after the
//   result is accepted.
// Reset: clears state, counts, full flag, totals (lowest start to all ones);
//   table contents are not cleared and are read only below the fill count.
`timescale 1ns / 1ps

module address_range_merge_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [armt_pkg::ADDR_W-1:0]   i_range_start,
    input  logic [armt_pkg::ADDR_W-1:0]   i_range_end,
    input  logic                          i_list_first,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [armt_pkg::PLACE_W-1:0]  o_placement,
    output logic [armt_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [armt_pkg::ADDR_W-1:0]   o_slot_start,
    output logic [armt_pkg::ADDR_W-1:0]   o_slot_end,
    output logic [armt_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                          o_overflowed,
    output logic [armt_pkg::TOTAL_W-1:0]  o_range_count,
    output logic [armt_pkg::ADDR_W-1:0]   o_lowest_start,
    output logic [armt_pkg::ADDR_W-1:0]   o_highest_end
);

    armt_pkg::t_armt_cmd w_cmd;
    armt_pkg::t_armt_sts w_sts;

    // Sequencer
    armt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // Table and totals
    armt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .i_list_first   (i_list_first),
        .o_sts          (w_sts),
        .o_placement    (o_placement),
        .o_slot_index   (o_slot_index),
        .o_slot_start   (o_slot_start),
        .o_slot_end     (o_slot_end),
        .o_entry_count  (o_entry_count),
        .o_overflowed   (o_overflowed),
        .o_range_count  (o_range_count),
        .o_lowest_start (o_lowest_start),
        .o_highest_end  (o_highest_end)
    );

    // The block never takes an item while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while result pending");
    // A dropped item always shows the sticky overflow
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_placement == armt_pkg::PLACE_DROP)) |-> o_overflowed)
        else $error("drop without overflow flag");
    // An appended item lands in the last slot
    a_append_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_placement == armt_pkg::PLACE_APPEND)) |->
        (o_slot_index == armt_pkg::SLOT_W'(o_entry_count - 4'd1)))
        else $error("append slot is not the last entry");
    // Every result counts at least its own item
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_count != '0))
        else $error("result with zero range count");

endmodule
